[hdl/fpr_pkg.sv]
package fpr_pkg;

   localparam logic [7:0] START_BYTE = 8'h2E;
   localparam logic [7:0] SUM_INVERT = 8'hFF;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_ACK     = 1'b1;

   typedef struct packed {
      logic       checksum_ok;
      logic [7:0] frame_length;
      logic [7:0] frame_command;
      logic [4:0] payload_index;
      logic [7:0] payload_byte;
      logic       kind;
   } result_type;

endpackage

[hdl/fpr_frame_fsm.sv]
module fpr_frame_fsm #(
   parameter int MAX_FRAME = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         rx_byte,
   output logic               res_valid,
   output fpr_pkg::result_type res
);
   import fpr_pkg::*;

   localparam logic [2:0] PH_WAIT = 3'd0;
   localparam logic [2:0] PH_CMD  = 3'd1;
   localparam logic [2:0] PH_LEN  = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_CSUM = 3'd4;

   localparam logic [5:0] FRAME_LIMIT = 6'(MAX_FRAME);

   logic [2:0] phase_ff, phase_in;
   logic [5:0] count_ff, count_in;
   logic [7:0] command_ff, command_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] sum_ff, sum_in;
   logic [5:0] count_inc;
   logic [7:0] sum_add;
   logic [5:0] data_seen;

   assign count_inc = count_ff + 6'd1;
   assign sum_add   = sum_ff + rx_byte;
   // payload bytes taken so far, including this one
   assign data_seen = count_ff - 6'd2;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      command_in = command_ff;
      length_in  = length_ff;
      sum_in     = sum_ff;
      res_valid  = 1'b0;
      res        = '0;
      if (step) begin
         case (phase_ff)
            PH_CMD, PH_LEN, PH_DATA, PH_CSUM: begin
               if (count_ff >= FRAME_LIMIT) begin
                  // frame overrun: drop silently
                  phase_in = PH_WAIT;
               end else begin
                  count_in = count_inc;
                  case (phase_ff)
                     PH_CMD: begin
                        command_in = rx_byte;
                        sum_in     = sum_add;
                        phase_in   = PH_LEN;
                     end
                     PH_LEN: begin
                        length_in = rx_byte;
                        sum_in    = sum_add;
                        phase_in  = (rx_byte != 8'd0) ? PH_DATA : PH_CSUM;
                     end
                     PH_DATA: begin
                        sum_in = sum_add;
                        if ({2'b00, data_seen} >= length_ff) begin
                           phase_in = PH_CSUM;
                        end
                        res_valid         = 1'b1;
                        res.kind          = KIND_PAYLOAD;
                        res.payload_byte  = rx_byte;
                        res.payload_index = 5'(count_ff - 6'd3);
                     end
                     default: begin
                        phase_in          = PH_WAIT;
                        res_valid         = 1'b1;
                        res.kind          = KIND_ACK;
                        res.frame_command = command_ff;
                        res.frame_length  = length_ff;
                        res.checksum_ok   = (rx_byte == (sum_ff ^ SUM_INVERT));
                     end
                  endcase
               end
            end
            default: begin
               if (rx_byte == START_BYTE) begin
                  phase_in   = PH_CMD;
                  count_in   = 6'd1;
                  sum_in     = 8'd0;
                  command_in = 8'd0;
                  length_in  = 8'd0;
               end else begin
                  phase_in = PH_WAIT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WAIT;
         count_ff   <= 6'd0;
         command_ff <= 8'd0;
         length_ff  <= 8'd0;
         sum_ff     <= 8'd0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         sum_ff     <= sum_in;
      end
   end

endmodule

[hdl/framed_packet_receiver.sv]
// Channel   Direction  tdata                        tuser
// req_      in         rx_byte                      -
// rsp_      out        see rsp_tdata                kind
//
// One item per cycle unless the result stalls: an input register, the frame
// state machine and a result register lie between req accept and rsp_tvalid.
// Reset is synchronous and returns the receiver to hunting for the start byte.
// A stalled result holds in the output register while the input register
// still takes one more item; req_tready then stays low until rsp_tready.
module framed_packet_receiver #(
   parameter int MAX_FRAME = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] payload_byte, [12:8] payload_index, [20:13] frame_command,
   // [28:21] frame_length, [29] checksum_ok, [31:30] zero
   output logic [31:0] rsp_tdata,
   output logic        rsp_tuser    // [0] kind
);
   import fpr_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       advance;
   logic       res_valid;
   result_type res;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   fpr_frame_fsm #(
      .MAX_FRAME (MAX_FRAME)
   ) u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = res_valid;
         out_in       = res;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {2'b00, out_ff.checksum_ok, out_ff.frame_length,
                        out_ff.frame_command, out_ff.payload_index,
                        out_ff.payload_byte};

endmodule
